// ===== rtl/lqsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed quicksort package
// Shared widths, record types and the range stack entry layout.
// ----------------------------------------------------------------------------
package lqsk_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int REC_BITS = KEY_BITS + TAG_BITS;

    // Pending ranges are disjoint and hold two or more records each.
    localparam int STK_DEPTH    = (DEPTH / 2 > 1) ? DEPTH / 2 : 2;
    localparam int STK_IDX_BITS = $clog2(STK_DEPTH);
    localparam int STK_CNT_BITS = $clog2(STK_DEPTH + 1);

    typedef logic [IDX_BITS-1:0]     t_idx;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [STK_IDX_BITS-1:0] t_sidx;
    typedef logic [STK_CNT_BITS-1:0] t_scnt;

    typedef struct packed {
        logic [KEY_BITS-1:0] sort_key;
        logic [TAG_BITS-1:0] record_tag;
        logic                batch_last;
    } t_in_word;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic [TAG_BITS-1:0] sorted_tag;
        logic                run_last;
    } t_out_word;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_rec;

    typedef struct packed {
        t_idx lo;
        t_idx hi;
    } t_range;

    // Record store port request: one read and one write per cycle.
    typedef struct packed {
        logic re;
        t_idx raddr;
        logic we;
        t_idx waddr;
        t_rec wdata;
    } t_mem_req;

endpackage

// ===== rtl/lqsk_rec_store.sv =====
// ----------------------------------------------------------------------------
// Keyed quicksort record store
// Record memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lqsk_rec_store (
    input  logic                  i_clk,
    input  lqsk_pkg::t_mem_req    i_req,
    output lqsk_pkg::t_rec        o_rdata
);
    import lqsk_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lqsk_range_stack.sv =====
// ----------------------------------------------------------------------------
// Keyed quicksort range stack
// Stack of pending index ranges, replacing recursion.
// ----------------------------------------------------------------------------
module lqsk_range_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_push,
    input  lqsk_pkg::t_range    i_push_data,
    input  logic                i_pop,
    output lqsk_pkg::t_range    o_top,
    output logic                o_empty
);
    import lqsk_pkg::*;

    t_range r_mem [STK_DEPTH];
    t_scnt  r_sp;
    t_scnt  n_sp;

    always_comb begin
        n_sp = r_sp;
        if (i_clear) begin
            n_sp = '0;
        end else if (i_push) begin
            n_sp = r_sp + t_scnt'(1);
        end else if (i_pop) begin
            n_sp = r_sp - t_scnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !i_clear) begin
            r_mem[r_sp[STK_IDX_BITS-1:0]] <= i_push_data;
        end
    end

    // The top entry is read combinationally; the stack is small and is read at one place.
    assign o_top   = r_mem[r_sp[STK_IDX_BITS-1:0] - t_sidx'(1)];
    assign o_empty = (r_sp == '0);

endmodule

// ===== rtl/lomuto_quicksort_keyed_core.sv =====
// ----------------------------------------------------------------------------
// Keyed Lomuto quicksort core
// Loads (key, tag) words, sorts the batch by key on the last word, and
// emits the sorted run.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle while the core is not busy. On a word
// marked batch_last the core goes busy, sorts the n stored records with a
// Lomuto quicksort and then emits n result words, one per cycle, strobed
// by o_valid; the receiver cannot stall them. Each partition step reads one
// record through the single registered read port of the record store and
// compares it with the pivot; a swap adds two store writes, and each range
// also needs a pop, a pivot read, a final pivot swap and two pushes. An
// already sorted batch is the worst case. Words beyond the store depth are
// dropped.
module lomuto_quicksort_keyed_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lqsk_pkg::t_in_word    i_data,
    output logic                  o_valid,
    output lqsk_pkg::t_out_word   o_data
);
    import lqsk_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_PIVW, S_RDJ, S_CMP, S_SWPA, S_SWPB,
        S_FINA, S_FINB, S_PUSH, S_OUTRD, S_OUT
    } t_state;

    t_state    r_state;
    t_cnt      r_count;
    t_idx      r_lo, r_hi, r_j, r_place;
    t_rec      r_pivot;
    t_rec      r_jrec;
    logic      r_fin;
    t_cnt      r_oidx;
    logic      r_ovalid;
    t_out_word r_odata;
    logic      r_push_lo;

    t_mem_req  mreq;
    t_rec      rdata;
    logic      s_push, s_pop, s_clear;
    t_range    s_push_data, s_top;
    logic      s_empty;
    t_idx      s_last_idx;
    logic      accept;

    lqsk_rec_store u_store (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    lqsk_range_stack u_stack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(s_clear),
        .i_push(s_push), .i_push_data(s_push_data), .i_pop(s_pop),
        .o_top(s_top), .o_empty(s_empty)
    );

    assign accept = start && !busy;
    assign busy   = (r_state != S_LOAD);

    assign s_last_idx = (r_count < t_cnt'(DEPTH)) ? r_count[IDX_BITS-1:0]
                                                   : t_idx'(DEPTH - 1);

    // Store and stack controls are decoded from the state.
    always_comb begin
        mreq        = '0;
        s_push      = 1'b0;
        s_pop       = 1'b0;
        s_clear     = 1'b0;
        s_push_data = '0;
        unique case (r_state)
            S_LOAD: begin
                mreq.we    = accept && (r_count < t_cnt'(DEPTH));
                mreq.waddr = r_count[IDX_BITS-1:0];
                mreq.wdata = '{key: i_data.sort_key, tag: i_data.record_tag};
                s_clear    = accept && !i_data.batch_last;
                if (accept && i_data.batch_last && (r_count != '0)) begin
                    // Seed the whole batch as the first range.
                    s_push      = 1'b1;
                    s_push_data = '{lo: '0, hi: s_last_idx};
                end
            end
            S_POP: begin
                s_pop     = !s_empty;
                mreq.re   = !s_empty;
                mreq.raddr = s_top.hi;
            end
            S_PIVW: ;
            S_RDJ: begin
                mreq.re    = 1'b1;
                mreq.raddr = r_j;
            end
            S_CMP: begin
                mreq.re    = 1'b1;
                mreq.raddr = r_place;
            end
            S_SWPA: begin
                // Old record at place moves to j, record j moves to place.
                mreq.we    = 1'b1;
                mreq.waddr = r_j;
                mreq.wdata = rdata;
            end
            S_SWPB: begin
                mreq.we    = 1'b1;
                mreq.waddr = r_place;
                mreq.wdata = r_jrec;
            end
            S_FINA: begin
                mreq.re    = 1'b1;
                mreq.raddr = r_place;
            end
            S_FINB: ;
            S_PUSH: begin
                if (r_push_lo) begin
                    s_push      = (r_place > r_lo + t_idx'(1)) && (r_place != '0);
                    s_push_data = '{lo: r_lo, hi: r_place - t_idx'(1)};
                end else begin
                    s_push      = ({1'b0, r_place} + {{IDX_BITS{1'b0}}, 1'b1})
                                  < {1'b0, r_hi};
                    s_push_data = '{lo: r_place + t_idx'(1), hi: r_hi};
                end
            end
            S_OUTRD: begin
                mreq.re    = 1'b1;
                mreq.raddr = r_oidx[IDX_BITS-1:0];
            end
            S_OUT: begin
                mreq.re    = (r_oidx < r_count);
                mreq.raddr = r_oidx[IDX_BITS-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_oidx    <= '0;
            r_push_lo <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (r_count < t_cnt'(DEPTH)) begin
                            r_count <= r_count + t_cnt'(1);
                        end
                        if (i_data.batch_last) begin
                            r_oidx <= '0;
                            // A batch of one needs no sorting.
                            if (r_count == '0) r_state <= S_OUTRD;
                            else               r_state <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    if (s_empty) begin
                        r_oidx  <= '0;
                        r_state <= S_OUTRD;
                    end else begin
                        r_lo    <= s_top.lo;
                        r_hi    <= s_top.hi;
                        r_place <= s_top.lo;
                        r_j     <= s_top.lo;
                        r_state <= S_PIVW;
                    end
                end
                S_PIVW: begin
                    r_pivot <= rdata;
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_jrec <= rdata;
                    if (rdata.key < r_pivot.key) begin
                        r_state <= S_SWPA;
                    end else if (r_j + t_idx'(1) == r_hi) begin
                        r_state <= S_FINA;
                    end else begin
                        r_j     <= r_j + t_idx'(1);
                        r_state <= S_RDJ;
                    end
                end
                S_SWPA: begin
                    r_state <= S_SWPB;
                end
                S_SWPB: begin
                    if (r_fin) begin
                        // The pivot is in its final place; push the two sides.
                        r_fin     <= 1'b0;
                        r_push_lo <= 1'b0;
                        r_state   <= S_PUSH;
                    end else begin
                        r_place <= r_place + t_idx'(1);
                        if (r_j + t_idx'(1) == r_hi) begin
                            r_state <= S_FINA;
                        end else begin
                            r_j     <= r_j + t_idx'(1);
                            r_state <= S_RDJ;
                        end
                    end
                end
                S_FINA: begin
                    r_j     <= r_hi;
                    r_state <= S_FINB;
                end
                S_FINB: begin
                    // Swap place with pivot at hi: record at hi is the pivot.
                    r_jrec  <= r_pivot;
                    r_state <= S_SWPA;
                    r_fin   <= 1'b1;
                end
                S_PUSH: begin
                    if (r_push_lo) begin
                        r_push_lo <= 1'b0;
                        r_state   <= S_POP;
                    end else begin
                        r_push_lo <= 1'b1;
                    end
                end
                S_OUTRD: begin
                    r_oidx  <= r_oidx + t_cnt'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= '{sorted_key: rdata.key, sorted_tag: rdata.tag,
                                  run_last: (r_oidx == r_count)};
                    if (r_oidx == r_count) begin
                        r_count <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_oidx <= r_oidx + t_cnt'(1);
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_no_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !$past(r_state == S_OUT)) |-> !o_valid)
        else $error("result word outside output phase");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("record count beyond depth");
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j < r_hi && r_place <= r_j))
        else $error("partition index out of range");

endmodule
